/* src/gwr_pkg.sv */
// ----------------------------------------------------------------------------
// gwr_pkg: shared types and constants of the grid wave router
// Cell encoding, request/response payloads, ring control and neighbor offsets.
// ----------------------------------------------------------------------------
package gwr_pkg;

  localparam int GRID_MAX  = 16;
  localparam int CELLS     = GRID_MAX * GRID_MAX;
  // window center inside the ring; leaves room for the (-1,-1) tap one stage
  // below it, where a load for that tap lands after the shift
  localparam int HEAD_POS  = GRID_MAX + 2;
  localparam int NUM_DIRS  = 8;
  localparam int IDX_W     = $clog2(CELLS);

  typedef enum logic [1:0] {
    KIND_EMPTY = 2'd0,
    KIND_WALL  = 2'd1,
    KIND_LABEL = 2'd2,
    KIND_PATH  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_SOLVE = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic {
    CFG_GRID_SIZE = 1'b0,
    CFG_NBR_MODE  = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_SEED,
    ST_WAVE,
    ST_TRACE,
    ST_REPLY
  } state_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] label;
  } cell_t;

  typedef struct packed {
    op_e        opcode;
    logic [3:0] cell_x;
    logic [3:0] cell_y;
    logic       make_wall;
    logic       keep_walls;
  } req_t;

  typedef struct packed {
    kind_e      cell_kind;
    logic [7:0] cell_label;
    logic       path_found;
    logic [7:0] path_length;
    logic       rejected;
  } rsp_t;

  typedef struct packed {
    logic       clr_all;   // every cell to empty
    logic       clr_lab;   // every non-wall cell to empty
    logic       hd_ld;     // rewrite the head cell
    cell_t      hd_data;
    logic       tap_ld;    // mark one neighbor tap as path
    logic [2:0] tap_dir;
  } ring_ctl_t;

  localparam cell_t EMPTY_CELL = '{kind: KIND_EMPTY, label: 8'd0};
  localparam cell_t PATH_CELL  = '{kind: KIND_PATH,  label: 8'd0};

  // Direction order: (0,+1),(0,-1),(+1,0),(-1,0),(+1,+1),(-1,+1),(-1,-1),(+1,-1)
  function automatic logic [4:0] dir_dx(input int k);
    logic [4:0] r;
    case (k)
      2, 4, 7: r = 5'd1;
      3, 5, 6: r = 5'h1f;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] dir_dy(input int k);
    logic [4:0] r;
    case (k)
      0, 4, 5: r = 5'd1;
      1, 6, 7: r = 5'h1f;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  // Ring distance of a neighbor: cells are ordered x outer, y inner
  function automatic int dir_ofs(input int k);
    int r;
    case (k)
      0:       r = 1;
      1:       r = -1;
      2:       r = GRID_MAX;
      3:       r = -GRID_MAX;
      4:       r = GRID_MAX + 1;
      5:       r = -GRID_MAX + 1;
      6:       r = -GRID_MAX - 1;
      7:       r = GRID_MAX - 1;
      default: r = 0;
    endcase
    return r;
  endfunction

endpackage

/* src/gwr_cell.sv */
// ----------------------------------------------------------------------------
// gwr_cell: one stage of the rotating cell ring
// Takes its neighbor's entry every cycle, with clear and load overrides.
// ----------------------------------------------------------------------------
module gwr_cell import gwr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cell_t shift_i,
  input  logic  clr_all_i,
  input  logic  clr_lab_i,
  input  logic  ld_i,
  input  cell_t ld_data_i,
  output cell_t q_o
);

  cell_t cell_q, cell_d;

  always_comb begin
    cell_d = shift_i;
    if (clr_all_i) begin
      cell_d = EMPTY_CELL;
    end else if (clr_lab_i && shift_i.kind != KIND_WALL) begin
      cell_d = EMPTY_CELL;
    end else if (ld_i) begin
      cell_d = ld_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= EMPTY_CELL;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign q_o = cell_q;

endmodule

/* src/gwr_ctrl.sv */
// ----------------------------------------------------------------------------
// gwr_ctrl: sequencer of the grid wave router
// Tracks which cell sits at the ring head, runs wave passes and the
// backtrace over the neighbor window, and holds config and the reply slot.
// ----------------------------------------------------------------------------
module gwr_ctrl import gwr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  cfg_idx_e  cfg_idx_i,
  input  logic [4:0] cfg_wdata_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  req_t      in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output rsp_t      out_data_o,
  input  cell_t     head_i,
  input  cell_t     nbr_i [NUM_DIRS],
  output ring_ctl_t ctl_o
);

  state_e           state_q, state_d;
  logic [IDX_W-1:0] head_idx_q;
  logic [4:0]       grid_n_q;
  logic             mode_q;
  req_t             req_q, req_d;
  rsp_t             reply_q, reply_d, out_data_q, out_data_d;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       level_q, level_d;
  logic [7:0]       pass_cnt_q, pass_cnt_d;
  logic             added_q, added_d, end_hit_q, end_hit_d;
  logic [IDX_W-1:0] cursor_q, cursor_d;
  logic [7:0]       trace_cnt_q, trace_cnt_d;
  logic [7:0]       path_len_q, path_len_d;

  logic [3:0]       n_m1, hx, hy;
  logic [IDX_W-1:0] end_idx, in_idx, req_idx;
  logic             in_in_grid, wr_bad, head_in, slot_free, at_cur;
  logic [NUM_DIRS-1:0] nb_ok, lab_hit, tr_hit;
  logic             grow, pass_last, hit_now, add_now, tr_any;
  logic [2:0]       tr_dir;
  logic [8:0]       level_nx;
  logic [4:0]       size_sat;

  assign n_m1       = 4'(grid_n_q - 5'd1);
  assign end_idx    = {n_m1, n_m1};
  assign in_idx     = {in_data_i.cell_x, in_data_i.cell_y};
  assign req_idx    = {req_q.cell_x, req_q.cell_y};
  assign in_in_grid = ({1'b0, in_data_i.cell_x} < grid_n_q) &&
                      ({1'b0, in_data_i.cell_y} < grid_n_q);
  assign wr_bad     = !in_in_grid || in_idx == '0 || in_idx == end_idx;
  assign hx         = head_idx_q[7:4];
  assign hy         = head_idx_q[3:0];
  assign head_in    = ({1'b0, hx} < grid_n_q) && ({1'b0, hy} < grid_n_q);
  assign slot_free  = !out_valid_q || out_ready_i;
  assign at_cur     = head_idx_q == cursor_q;
  assign pass_last  = pass_cnt_q == 8'hff;
  assign level_nx   = {1'b0, level_q} + 9'd1;

  always_comb begin
    for (int k = 0; k < NUM_DIRS; k++) begin
      nb_ok[k] = (k < 4 || mode_q) &&
                 (5'({1'b0, hx} + dir_dx(k)) < grid_n_q) &&
                 (5'({1'b0, hy} + dir_dy(k)) < grid_n_q);
      lab_hit[k] = nb_ok[k] && nbr_i[k].kind == KIND_LABEL && nbr_i[k].label == level_q;
      tr_hit[k]  = nb_ok[k] && nbr_i[k].kind == KIND_LABEL &&
                   nbr_i[k].label == 8'(trace_cnt_q - 8'd1);
    end
  end

  // first matching direction wins
  always_comb begin
    tr_dir = 3'd0;
    for (int k = NUM_DIRS - 1; k >= 0; k--) begin
      if (tr_hit[k]) tr_dir = 3'(k);
    end
  end

  assign tr_any  = |tr_hit;
  assign grow    = head_in && head_i.kind == KIND_EMPTY && |lab_hit;
  assign hit_now = end_hit_q || (grow && head_idx_q == end_idx);
  assign add_now = added_q || grow;

  always_comb begin
    if (cfg_wdata_i < 5'd2) begin
      size_sat = 5'd2;
    end else if (cfg_wdata_i > 5'(GRID_MAX)) begin
      size_sat = 5'(GRID_MAX);
    end else begin
      size_sat = cfg_wdata_i;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (in_data_i.opcode)
            OP_WRITE: state_d = wr_bad ? ST_REPLY : ST_WRITE;
            OP_SOLVE: state_d = ST_SEED;
            OP_READ:  state_d = in_in_grid ? ST_READ : ST_REPLY;
            OP_CLEAR: state_d = ST_REPLY;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_WRITE, ST_READ: begin
        if (head_idx_q == req_idx) state_d = ST_REPLY;
      end
      ST_SEED: begin
        if (head_idx_q == '0) state_d = ST_WAVE;
      end
      ST_WAVE: begin
        if (pass_last) begin
          if (hit_now) begin
            state_d = ST_TRACE;
          end else if (!add_now || level_nx >= 9'd255) begin
            state_d = ST_REPLY;
          end
        end
      end
      ST_TRACE: begin
        if (at_cur && (!tr_any || trace_cnt_q == 8'd1)) state_d = ST_REPLY;
      end
      ST_REPLY: begin
        if (slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    ctl_o       = '0;
    ctl_o.hd_data = EMPTY_CELL;
    req_d       = req_q;
    reply_d     = reply_q;
    level_d     = level_q;
    pass_cnt_d  = pass_cnt_q;
    added_d     = added_q;
    end_hit_d   = end_hit_q;
    cursor_d    = cursor_q;
    trace_cnt_d = trace_cnt_q;
    path_len_d  = path_len_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;

    if (cfg_we_i && cfg_idx_i == CFG_GRID_SIZE) ctl_o.clr_all = 1'b1;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_data_i;
          reply_d = '0;
          case (in_data_i.opcode)
            OP_WRITE: reply_d.rejected = wr_bad;
            OP_SOLVE: ctl_o.clr_lab = 1'b1;
            OP_CLEAR: begin
              ctl_o.clr_all = !in_data_i.keep_walls;
              ctl_o.clr_lab = in_data_i.keep_walls;
            end
            default: ;
          endcase
        end
      end
      ST_WRITE: begin
        if (head_idx_q == req_idx) begin
          ctl_o.hd_ld   = 1'b1;
          ctl_o.hd_data = '{kind: req_q.make_wall ? KIND_WALL : KIND_EMPTY, label: 8'd0};
        end
      end
      ST_READ: begin
        if (head_idx_q == req_idx) begin
          reply_d.cell_kind  = head_i.kind;
          reply_d.cell_label = (head_i.kind == KIND_LABEL) ? head_i.label : 8'd0;
        end
      end
      ST_SEED: begin
        if (head_idx_q == '0) begin
          ctl_o.hd_ld   = 1'b1;
          ctl_o.hd_data = '{kind: KIND_LABEL, label: 8'd0};
          level_d       = 8'd0;
          pass_cnt_d    = 8'd0;
          added_d       = 1'b0;
          end_hit_d     = 1'b0;
        end
      end
      ST_WAVE: begin
        ctl_o.hd_ld   = grow;
        ctl_o.hd_data = '{kind: KIND_LABEL, label: level_nx[7:0]};
        pass_cnt_d    = 8'(pass_cnt_q + 8'd1);
        added_d       = add_now;
        end_hit_d     = hit_now;
        if (pass_last) begin
          level_d   = level_nx[7:0];
          added_d   = 1'b0;
          end_hit_d = 1'b0;
          if (hit_now) begin
            path_len_d  = level_nx[7:0];
            trace_cnt_d = level_nx[7:0];
            cursor_d    = end_idx;
          end else if (!add_now || level_nx >= 9'd255) begin
            reply_d.path_found  = 1'b0;
            reply_d.path_length = 8'd0;
          end
        end
      end
      ST_TRACE: begin
        if (at_cur) begin
          ctl_o.tap_ld  = tr_any;
          ctl_o.tap_dir = tr_dir;
          cursor_d      = 8'(head_idx_q + 8'(dir_ofs(int'(tr_dir))));
          trace_cnt_d   = 8'(trace_cnt_q - 8'd1);
          if (!tr_any || trace_cnt_q == 8'd1) begin
            reply_d.path_found  = 1'b1;
            reply_d.path_length = path_len_q;
          end
        end
      end
      ST_REPLY: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_data_d  = reply_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_idx_q  <= '0;
      grid_n_q    <= 5'(GRID_MAX);
      mode_q      <= 1'b0;
      out_valid_q <= 1'b0;
      level_q     <= '0;
      pass_cnt_q  <= '0;
      added_q     <= 1'b0;
      end_hit_q   <= 1'b0;
      cursor_q    <= '0;
      trace_cnt_q <= '0;
    end else begin
      state_q     <= state_d;
      head_idx_q  <= IDX_W'(head_idx_q + 1'b1);
      out_valid_q <= out_valid_d;
      level_q     <= level_d;
      pass_cnt_q  <= pass_cnt_d;
      added_q     <= added_d;
      end_hit_q   <= end_hit_d;
      cursor_q    <= cursor_d;
      trace_cnt_q <= trace_cnt_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_GRID_SIZE: grid_n_q <= size_sat;
          CFG_NBR_MODE:  mode_q   <= cfg_wdata_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    reply_q    <= reply_d;
    out_data_q <= out_data_d;
    path_len_q <= path_len_d;
  end

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* src/grid_wave_router.sv */
// ----------------------------------------------------------------------------
// grid_wave_router: Lee wave maze router over a rotating ring of grid cells
//
//   channel   direction  handshake              payload
//   config    in         cfg_we_i               cfg_idx_i, cfg_wdata_i
//   request   in         in_valid_i/in_ready_o  in_data_i  (req_t)
//   result    out        out_valid_o/out_ready_i out_data_o (rsp_t)
//
// All 256 cells rotate one ring stage per cycle past a fixed window (head
// cell and its eight neighbor taps); every access waits for its cell there.
// Clear and rejected requests go straight to the reply; reads and writes wait for their cell.
// Solve: a wait to seed, a full ring pass per wave level, then a wait per path step.
// One request is in work at a time; a held result blocks only the next reply.
// Reset empties every cell at once, with no clearing pass.
// ----------------------------------------------------------------------------
module grid_wave_router import gwr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_we_i,
  input  cfg_idx_e cfg_idx_i,
  input  logic [4:0] cfg_wdata_i,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  req_t     in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output rsp_t     out_data_o
);

  cell_t      ring [CELLS];
  cell_t      nbr  [NUM_DIRS];
  logic [CELLS-1:0] cell_ld;
  ring_ctl_t  ctl;

  gwr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .head_i      (ring[HEAD_POS]),
    .nbr_i       (nbr),
    .ctl_o       (ctl)
  );

  for (genvar k = 0; k < NUM_DIRS; k++) begin : g_tap
    assign nbr[k] = ring[HEAD_POS + dir_ofs(k)];
  end

  // loads land one stage down, where the entry sits after this shift
  always_comb begin
    cell_ld = '0;
    cell_ld[HEAD_POS-1] = ctl.hd_ld;
    for (int k = 0; k < NUM_DIRS; k++) begin
      if (ctl.tap_ld && ctl.tap_dir == 3'(k)) cell_ld[HEAD_POS - 1 + dir_ofs(k)] = 1'b1;
    end
  end

  for (genvar i = 0; i < CELLS; i++) begin : g_ring
    gwr_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .shift_i   (ring[(i + 1) % CELLS]),
      .clr_all_i (ctl.clr_all),
      .clr_lab_i (ctl.clr_lab),
      .ld_i      (cell_ld[i]),
      .ld_data_i ((i == HEAD_POS - 1) ? ctl.hd_data : PATH_CELL),
      .q_o       (ring[i])
    );
  end

  a_ld_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl.hd_ld && ctl.tap_ld))
    else $error("head and tap load in the same cycle");

  a_no_ld_on_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.clr_all || ctl.clr_lab) |-> !(ctl.hd_ld || ctl.tap_ld))
    else $error("cell load during a grid clear");

  a_idle_no_ld: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !(ctl.hd_ld || ctl.tap_ld))
    else $error("cell load while no request is in work");

  a_one_ld: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cell_ld))
    else $error("more than one ring stage loaded");

endmodule
